// ===== design/lbwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbwd_pkg
// Shared types, constants and elaboration-time helpers of the log-spaced
// windowed DFT block.
// ----------------------------------------------------------------------------
package lbwd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BIN_OUT_W  = 6;
    localparam int MAG_W      = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int RATE_W     = 17;
    localparam int GAIN_W     = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_RATE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN = 2'd1;

    localparam logic [RATE_W-1:0] RATE_RESET   = 17'd44100;
    localparam logic [RATE_W-1:0] RATE_DEFAULT = 17'd44100;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd5000;

    // phase offset of a quarter turn: cos(p) = sin(p + quarter)
    localparam logic [31:0] PH_QUARTER = 32'h4000_0000;

    // sine polynomial, Q28
    localparam logic [28:0] SIN_C1 = 29'd421657428;
    localparam logic [27:0] SIN_C3 = 28'd173399668;
    localparam logic [24:0] SIN_C5 = 25'd21392326;
    localparam logic [20:0] SIN_C7 = 21'd1256749;
    localparam int          SIN_LAT = 5;

    // shared divider
    localparam int DIV_DVD_W = 48;
    localparam int DIV_DVS_W = 17;
    localparam int DIV_CNT_W = 6;

    localparam logic [1:0] DIV_HANN = 2'd0;
    localparam logic [1:0] DIV_STEP = 2'd1;
    localparam logic [1:0] DIV_MAG  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       close;
        logic       bin_clr;
        logic       bin_inc;
        logic       div_start;
        logic [1:0] div_sel;
        logic       bin_init;
        logic       issue;
        logic       absr;
        logic       sq;
        logic       sqrt_start;
        logic       scale;
        logic       out_load;
        logic       out_zero;
    } lbwd_cmd_t;

    typedef struct packed {
        logic short_win;
        logic bin_last;
        logic div_done;
        logic issue_last;
        logic pipe_busy;
        logic sqrt_busy;
        logic out_free;
    } lbwd_sta_t;

    // log2 in Q16 by repeated squaring (elaboration only)
    function automatic logic [63:0] log2_q16(input logic [31:0] x_in);
        logic [31:0] x;
        logic [5:0]  n;
        logic [63:0] m;
        logic [15:0] r;
        x = (x_in == 32'd0) ? 32'd1 : x_in;
        n = 6'd0;
        for (int j = 0; j < 31; j++) begin
            if ((x >> n) > 32'd1) n = n + 6'd1;
        end
        m = 64'(x) << (6'd30 - n);
        r = 16'd0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                r = r | 16'd1;
            end
        end
        return (64'(n) << 16) | 64'(r);
    endfunction

    // exp2 of a Q16 exponent, Q16 result (elaboration only)
    function automatic logic [63:0] exp2_q16(input longint e_in);
        logic [63:0] ue;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] mant;
        ue = (e_in < 0) ? 64'd0 : 64'(e_in);
        k  = ue >> 16;
        if (k > 64'd24) k = 64'd24;
        f = (ue & 64'hFFFF) << 14;
        t = 64'd1431680;
        t = 64'd10327388  + ((t * f) >> 30);
        t = 64'd59597083  + ((t * f) >> 30);
        t = 64'd257941248 + ((t * f) >> 30);
        t = 64'd744261118 + ((t * f) >> 30);
        mant = (64'd1 << 30) + ((t * f) >> 30);
        return (mant << k) >> 14;
    endfunction

endpackage

// ===== design/lbwd_ram.sv =====
// ----------------------------------------------------------------------------
// lbwd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbwd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/lbwd_sin.sv =====
// ----------------------------------------------------------------------------
// lbwd_sin
// Pipelined Q15 sine of a 32-bit phase, odd quarter-wave polynomial.
// ----------------------------------------------------------------------------
module lbwd_sin (
    input  logic               aclk,
    input  logic [31:0]        ph,
    output logic signed [15:0] val
);
    import lbwd_pkg::*;

    logic [16:0] x_in;
    logic [33:0] xx;
    logic [16:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic [16:0] q1_reg, q2_reg, q3_reg;
    logic        n1_reg, n2_reg, n3_reg, n4_reg;
    logic [24:0] a_reg;
    logic [27:0] b_reg;
    logic [28:0] c_reg;
    logic [37:0] pa;
    logic [41:0] pb;
    logic [44:0] pc;
    logic [45:0] pv;
    logic [16:0] v;

    // mirror in odd quarters
    assign x_in = ph[30] ? (17'h10000 - {1'b0, ph[29:14]}) : {1'b0, ph[29:14]};
    assign xx   = x_in * x_in;
    assign pa   = q1_reg * SIN_C7;
    assign pb   = q2_reg * a_reg;
    assign pc   = q3_reg * b_reg;
    assign pv   = x4_reg * c_reg;
    assign v    = pv[45:29];

    always_ff @(posedge aclk) begin
        x1_reg <= x_in;
        q1_reg <= xx[32:16];
        n1_reg <= ph[31];

        x2_reg <= x1_reg;
        q2_reg <= q1_reg;
        n2_reg <= n1_reg;
        a_reg  <= SIN_C5 - 25'(pa[37:16]);

        x3_reg <= x2_reg;
        q3_reg <= q2_reg;
        n3_reg <= n2_reg;
        b_reg  <= SIN_C3 - 28'(pb[41:16]);

        x4_reg <= x3_reg;
        n4_reg <= n3_reg;
        c_reg  <= SIN_C1 - pc[44:16];

        if (v > 17'd32767) begin
            val <= n4_reg ? -16'sd32767 : 16'sd32767;
        end else begin
            val <= n4_reg ? -$signed(v[15:0]) : $signed(v[15:0]);
        end
    end
endmodule

// ===== design/lbwd_div.sv =====
// ----------------------------------------------------------------------------
// lbwd_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module lbwd_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lbwd_pkg::DIV_DVD_W-1:0] dividend,
    input  logic [lbwd_pkg::DIV_DVS_W-1:0] divisor,
    output logic                           done,
    output logic [lbwd_pkg::DIV_DVD_W-1:0] quot,
    output logic [lbwd_pkg::DIV_DVS_W-1:0] rem
);
    import lbwd_pkg::*;

    logic [DIV_DVD_W-1:0] q_reg;
    logic [DIV_DVS_W-1:0] r_reg, d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIV_DVS_W:0]   r_sh;
    logic                 ge;

    assign r_sh = {r_reg, q_reg[DIV_DVD_W-1]};
    assign ge   = r_sh >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                q_reg   <= {q_reg[DIV_DVD_W-2:0], ge};
                r_reg   <= ge ? DIV_DVS_W'(r_sh - {1'b0, d_reg}) : r_sh[DIV_DVS_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

// ===== design/lbwd_dp.sv =====
// ----------------------------------------------------------------------------
// lbwd_dp
// Datapath: sample store, phase accumulators, MAC pipeline, magnitude unit,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module lbwd_dp #(
    parameter int WINDOW_LEN   = 1024,
    parameter int BIN_COUNT    = 32,
    parameter int LOW_FREQ_HZ  = 40,
    parameter int HIGH_FREQ_HZ = 16000
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lbwd_pkg::lbwd_cmd_t             cmd,
    output lbwd_pkg::lbwd_sta_t             sta,
    input  logic [lbwd_pkg::SAMPLE_W-1:0]   in_sample,
    input  logic                            cfg_we,
    input  logic [lbwd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lbwd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [lbwd_pkg::BIN_OUT_W-1:0]  out_bin,
    output logic [lbwd_pkg::MAG_W-1:0]      out_mag,
    output logic                            out_last
);
    import lbwd_pkg::*;

    localparam int AW    = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int HALF  = WINDOW_LEN / 2;
    localparam int PIPE  = SIN_LAT + 2;
    localparam longint L_LO = longint'(log2_q16(32'(LOW_FREQ_HZ)));
    localparam longint L_HI = longint'(log2_q16(32'(HIGH_FREQ_HZ)));

    // bin frequency table, Q16 Hz
    logic [31:0] fq_tab [BIN_COUNT];
    for (genvar g = 0; g < BIN_COUNT; g++) begin : g_fq
        localparam longint E_B = L_LO + (longint'(g) * (L_HI - L_LO)) / longint'(BIN_COUNT - 1);
        assign fq_tab[g] = 32'(exp2_q16(E_B));
    end

    logic [RATE_W-1:0] rate_reg, rate_eff;
    logic [GAIN_W-1:0] gain_reg;
    logic [CNT_W-1:0]  cnt_reg, len_reg, i_reg, cnt_inc;
    logic [BIN_W-1:0]  bin_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
            gain_reg <= GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RATE: rate_reg <= cfg_wdata;
                CFG_GAIN: gain_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end
    assign rate_eff = (rate_reg == '0) ? RATE_DEFAULT : rate_reg;

    // window load
    logic                        ram_we;
    logic signed [SAMPLE_W-1:0]  ram_rdata;
    assign ram_we  = cmd.load && (cnt_reg < CNT_W'(WINDOW_LEN));
    assign cnt_inc = ram_we ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.close) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.close) begin
            len_reg <= cnt_inc;
        end
        if (cmd.bin_clr) begin
            bin_reg <= '0;
        end else if (cmd.bin_inc) begin
            bin_reg <= bin_reg + 1'b1;
        end
    end

    lbwd_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_LEN)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (in_sample),
        .raddr (i_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // shared divider
    logic [DIV_DVD_W-1:0] dvd, quot;
    logic [DIV_DVS_W-1:0] dvs, rem;
    logic                 div_done;
    logic [1:0]           sel_reg;
    logic [47:0]          prod_reg;

    always_comb begin
        case (cmd.div_sel)
            DIV_HANN: begin
                dvd = DIV_DVD_W'(64'h1_0000_0000);
                dvs = DIV_DVS_W'(len_reg) - 1'b1;
            end
            DIV_STEP: begin
                dvd = {fq_tab[bin_reg], 16'h0};
                dvs = rate_eff;
            end
            DIV_MAG: begin
                dvd = DIV_DVD_W'(prod_reg[47:17]);
                dvs = DIV_DVS_W'(len_reg);
            end
            default: begin
                dvd = '0;
                dvs = DIV_DVS_W'(1);
            end
        endcase
    end

    lbwd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    logic [31:0]          hq_reg, step_reg;
    logic [DIV_DVS_W-1:0] hr_reg;
    logic [MAG_W-1:0]     mag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            sel_reg <= cmd.div_sel;
        end
        if (div_done) begin
            case (sel_reg)
                DIV_HANN: begin
                    hq_reg <= quot[31:0];
                    hr_reg <= rem;
                end
                DIV_STEP: step_reg <= quot[31:0];
                DIV_MAG:  mag_reg  <= (|quot[DIV_DVD_W-1:MAG_W]) ? '1 : quot[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    // phase accumulators: sample phase and exact Hann phase i*2^32/(len-1)
    logic [31:0]          ph_reg, hph_reg;
    logic [DIV_DVS_W-1:0] hrem_reg, lenm1;
    logic [DIV_DVS_W:0]   hsum;
    logic                 hwrap;

    assign lenm1 = DIV_DVS_W'(len_reg) - 1'b1;
    assign hsum  = {1'b0, hrem_reg} + {1'b0, hr_reg};
    assign hwrap = hsum >= {1'b0, lenm1};

    always_ff @(posedge aclk) begin
        if (cmd.bin_init) begin
            i_reg    <= '0;
            ph_reg   <= '0;
            hph_reg  <= '0;
            hrem_reg <= '0;
        end else if (cmd.issue) begin
            i_reg    <= i_reg + 1'b1;
            ph_reg   <= ph_reg + step_reg;
            hph_reg  <= hph_reg + hq_reg + 32'(hwrap);
            hrem_reg <= hwrap ? DIV_DVS_W'(hsum - {1'b0, lenm1}) : hsum[DIV_DVS_W-1:0];
        end
    end

    // MAC pipeline
    logic signed [15:0] hc, cv, sv;
    logic [PIPE-1:0]    iss_reg;

    lbwd_sin u_sin_h (.aclk(aclk), .ph(hph_reg + PH_QUARTER), .val(hc));
    lbwd_sin u_sin_c (.aclk(aclk), .ph(ph_reg + PH_QUARTER),  .val(cv));
    lbwd_sin u_sin_s (.aclk(aclk), .ph(ph_reg),               .val(sv));

    logic signed [SAMPLE_W-1:0] sd_reg [SIN_LAT-1];
    logic [16:0]                hn;
    logic [15:0]                h;
    logic signed [32:0]         ws_full;
    logic signed [31:0]         ws_reg;
    logic signed [15:0]         cd_reg, sdl_reg;
    logic signed [47:0]         re_full, im_full, re_t_reg, im_t_reg;
    logic signed [63:0]         re_reg, im_reg;

    assign hn      = 17'h08000 - 17'($signed(hc));
    assign h       = hn[16:1];
    assign ws_full = $signed(sd_reg[SIN_LAT-2]) * $signed({1'b0, h});
    assign re_full = ws_reg * cd_reg;
    assign im_full = ws_reg * sdl_reg;

    always_ff @(posedge aclk) begin
        sd_reg[0] <= ram_rdata;
        for (int k = 1; k < SIN_LAT - 1; k++) begin
            sd_reg[k] <= sd_reg[k-1];
        end
        ws_reg   <= ws_full[31:0];
        cd_reg   <= cv;
        sdl_reg  <= sv;
        re_t_reg <= re_full;
        im_t_reg <= im_full;
        if (cmd.bin_init) begin
            re_reg <= '0;
            im_reg <= '0;
        end else if (iss_reg[PIPE-1]) begin
            re_reg <= re_reg + {{16{re_t_reg[47]}}, re_t_reg};
            im_reg <= im_reg + {{16{im_t_reg[47]}}, im_t_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg <= '0;
        end else begin
            iss_reg <= {iss_reg[PIPE-2:0], cmd.issue};
        end
    end

    // magnitude: abs, square, integer square root, gain
    logic [63:0] re_u, im_u, sqa_reg, sqc_reg, sv_reg, sr_reg, sbit_reg, st;
    logic [31:0] a_reg, c_reg;

    assign re_u = re_reg[63] ? (~re_reg + 64'd1) : re_reg;
    assign im_u = im_reg[63] ? (~im_reg + 64'd1) : im_reg;
    assign st   = sr_reg + sbit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.absr) begin
            a_reg <= re_u[58:27];
            c_reg <= im_u[58:27];
        end
        if (cmd.sq) begin
            sqa_reg <= a_reg * a_reg;
            sqc_reg <= c_reg * c_reg;
        end
        if (cmd.scale) begin
            prod_reg <= sr_reg[31:0] * gain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbit_reg <= '0;
        end else if (cmd.sqrt_start) begin
            sv_reg   <= sqa_reg + sqc_reg;
            sr_reg   <= '0;
            sbit_reg <= 64'h4000_0000_0000_0000;
        end else if (|sbit_reg) begin
            if (sv_reg >= st) begin
                sv_reg <= sv_reg - st;
                sr_reg <= (sr_reg >> 1) + sbit_reg;
            end else begin
                sr_reg <= sr_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // result register
    logic out_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_bin  <= BIN_OUT_W'(bin_reg);
            out_mag  <= cmd.out_zero ? '0 : mag_reg;
            out_last <= bin_reg == BIN_W'(BIN_COUNT - 1);
        end
    end

    assign out_valid = out_valid_reg;

    assign sta.short_win  = (len_reg < CNT_W'(HALF)) || (len_reg < CNT_W'(2));
    assign sta.bin_last   = bin_reg == BIN_W'(BIN_COUNT - 1);
    assign sta.div_done   = div_done;
    assign sta.issue_last = i_reg == len_reg - 1'b1;
    assign sta.pipe_busy  = |iss_reg;
    assign sta.sqrt_busy  = |sbit_reg;
    assign sta.out_free   = !out_valid_reg || out_ready;
endmodule

// ===== design/lbwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbwd_ctrl
// Controller: window load, per-bin sequencing and result emission.
// ----------------------------------------------------------------------------
module lbwd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  lbwd_pkg::lbwd_sta_t sta,
    output lbwd_pkg::lbwd_cmd_t cmd
);
    import lbwd_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_ZERO   = 4'd2;
    localparam logic [3:0] ST_HDIV_W = 4'd3;
    localparam logic [3:0] ST_STEP_S = 4'd4;
    localparam logic [3:0] ST_SDIV_W = 4'd5;
    localparam logic [3:0] ST_RUN    = 4'd6;
    localparam logic [3:0] ST_DRAIN  = 4'd7;
    localparam logic [3:0] ST_SQ     = 4'd8;
    localparam logic [3:0] ST_SQS    = 4'd9;
    localparam logic [3:0] ST_SQW    = 4'd10;
    localparam logic [3:0] ST_SCALE  = 4'd11;
    localparam logic [3:0] ST_MDIV_S = 4'd12;
    localparam logic [3:0] ST_MDIV_W = 4'd13;
    localparam logic [3:0] ST_EMIT   = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.close  = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cmd.bin_clr = 1'b1;
                if (sta.short_win) begin
                    state_next = ST_ZERO;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_HANN;
                    state_next    = ST_HDIV_W;
                end
            end
            ST_ZERO: begin
                if (sta.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = 1'b1;
                    if (sta.bin_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.bin_inc = 1'b1;
                    end
                end
            end
            ST_HDIV_W: begin
                if (sta.div_done) state_next = ST_STEP_S;
            end
            ST_STEP_S: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_STEP;
                state_next    = ST_SDIV_W;
            end
            ST_SDIV_W: begin
                if (sta.div_done) begin
                    cmd.bin_init = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (sta.issue_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!sta.pipe_busy) begin
                    cmd.absr   = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_SQS;
            end
            ST_SQS: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQW;
            end
            ST_SQW: begin
                if (!sta.sqrt_busy) state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_MDIV_S;
            end
            ST_MDIV_S: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MAG;
                state_next    = ST_MDIV_W;
            end
            ST_MDIV_W: begin
                if (sta.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sta.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sta.bin_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.bin_inc = 1'b1;
                        state_next  = ST_STEP_S;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== design/log_bin_windowed_dft.sv =====
// Sequence: samples are accepted back to back while idle; after the last one a full
//   window runs the Hann step divide, then per bin the step divide, the MAC pass,
//   the square root, the scale divide and the result; a short window gives one zero
//   result per unstalled cycle after the check state.
// Passes: one MAC pipeline makes BIN_COUNT passes over the window.
// Reset: synchronous, active low; clears counters and state, loads config defaults.
// ----------------------------------------------------------------------------
// log_bin_windowed_dft
// Hann-windowed single-frequency DFT at log-spaced bins, one magnitude per bin.
// ----------------------------------------------------------------------------
module log_bin_windowed_dft #(
    parameter int WINDOW_LEN   = 1024,
    parameter int BIN_COUNT    = 32,
    parameter int LOW_FREQ_HZ  = 40,
    parameter int HIGH_FREQ_HZ = 16000
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] sample
    input  logic                            s_tlast,   // last_sample
    // spectrum stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [5:0] bin_index, [13:6] magnitude
    output logic                            m_tlast,   // last_bin
    // configuration writes
    input  logic                            cfg_we,
    input  logic [lbwd_pkg::CFG_ADDR_W-1:0] cfg_addr,  // 0 sample_rate_hz, 1 output_gain
    input  logic [lbwd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lbwd_pkg::*;

    lbwd_cmd_t             cmd;
    lbwd_sta_t             sta;
    logic [BIN_OUT_W-1:0]  out_bin;
    logic [MAG_W-1:0]      out_mag;

    // The controller accepts samples only while idle; a last-marked transaction
    // closes the window and starts the per-bin passes. The result register
    // decouples the spectrum side, so the block returns to loading as soon as
    // the final bin is in that register.
    lbwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sta      (sta),
        .cmd      (cmd)
    );

    // Datapath holds the sample store, the shared divider (Hann step, phase
    // step, final scaling), three sine pipelines and the MAC accumulators.
    lbwd_dp #(
        .WINDOW_LEN   (WINDOW_LEN),
        .BIN_COUNT    (BIN_COUNT),
        .LOW_FREQ_HZ  (LOW_FREQ_HZ),
        .HIGH_FREQ_HZ (HIGH_FREQ_HZ)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sta       (sta),
        .in_sample (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_bin   (out_bin),
        .out_mag   (out_mag),
        .out_last  (m_tlast)
    );

    // pack fields from the lowest bit up, pad to whole bytes
    assign m_tdata = {2'b00, out_mag, out_bin};
endmodule

// ===== design/lbwd_chk.sv =====
// ----------------------------------------------------------------------------
// lbwd_chk
// Port-level checks of the windowed DFT block, bound to the top level.
// ----------------------------------------------------------------------------
module lbwd_chk #(
    parameter int BIN_COUNT = 32
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // last flag marks exactly the final bin
    a_last_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[5:0] == 6'(BIN_COUNT - 1))))
        else $error("last flag does not match final bin");

    // closing a window stops sample intake
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("sample accepted right after window close");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:14] == 2'b00)
        else $error("nonzero padding");
endmodule

bind log_bin_windowed_dft lbwd_chk #(.BIN_COUNT(BIN_COUNT)) u_lbwd_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
